>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, register codes, types and square-root step for the cord stepper
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int COORD_BITS = 16;
    localparam int BASE_W     = 16;
    localparam int LEN_W      = 18;
    localparam int DELTA_W    = LEN_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // absolute coordinate, signed, with room for origin add and base subtract
    localparam int X_W   = ((COORD_BITS > BASE_W) ? COORD_BITS : BASE_W) + 2;
    localparam int MAG_W = X_W - 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int RW    = (SUM_W + 1) / 2;
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X           = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y           = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_START_LEFT_LENGTH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_START_RIGHT_LENGTH = CFG_IDX_W'(4);

    localparam logic [BASE_W-1:0] BASE_LENGTH_RST = BASE_W'(26419);
    localparam logic [BASE_W-1:0] ORIGIN_X_RST    = BASE_W'(12639);
    localparam logic [BASE_W-1:0] ORIGIN_Y_RST    = BASE_W'(8580);
    localparam logic [LEN_W-1:0]  START_LEFT_RST  = LEN_W'(15278);
    localparam logic [LEN_W-1:0]  START_RIGHT_RST = LEN_W'(16233);

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // radicand sums leaving the front end
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] left_sum;
        logic [SUM_W-1:0] right_sum;
    } t_rad_item;

    // one square-root lane in flight
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [RW-1:0]    root;
    } t_lane;

    typedef struct packed {
        logic  valid;
        t_lane left;
        t_lane right;
    } t_cell;

    // one result bit of a digit-by-digit integer square root
    function automatic t_lane sqrt_step(t_lane l);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        t_lane            n;
        rem_sh = {l.rem, l.rad[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({l.root, 2'b01});
        n.rad  = {l.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n.rem  = REM_W'(rem_sh - trial);
            n.root = {l.root[RW-2:0], 1'b1};
        end else begin
            n.rem  = rem_sh[REM_W-1:0];
            n.root = {l.root[RW-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(logic [RW-1:0] root);
        logic [RW+LEN_W-1:0] wide;
        wide = (RW+LEN_W)'(root);
        if (wide > (RW+LEN_W)'(LEN_MAX)) begin
            return LEN_MAX;
        end else begin
            return wide[LEN_W-1:0];
        end
    endfunction

endpackage

>>> hdl/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// Origin add, base subtract, magnitudes, squares and sums of squares
// ----------------------------------------------------------------------------
module pcs_front
    import pcs_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_rel_x,
    input  logic signed [COORD_BITS-1:0] i_rel_y,
    input  logic        [BASE_W-1:0]     i_base_length,
    input  logic        [BASE_W-1:0]     i_origin_x,
    input  logic        [BASE_W-1:0]     i_origin_y,
    output t_rad_item                    o_q
);

    logic                  r_a_valid;
    logic signed [X_W-1:0] r_a_x;
    logic signed [X_W-1:0] r_a_y;
    logic                  r_b_valid;
    logic [MAG_W-1:0]      r_b_lx;
    logic [MAG_W-1:0]      r_b_rx;
    logic [MAG_W-1:0]      r_b_y;
    logic                  r_c_valid;
    logic [SQ_W-1:0]       r_c_lx2;
    logic [SQ_W-1:0]       r_c_rx2;
    logic [SQ_W-1:0]       r_c_y2;
    t_rad_item             r_d;

    logic signed [X_W-1:0] n_a_x;
    logic signed [X_W-1:0] n_a_y;
    logic signed [X_W-1:0] w_rx;
    logic signed [X_W-1:0] w_alx;
    logic signed [X_W-1:0] w_arx;
    logic signed [X_W-1:0] w_ay;

    always_comb begin
        n_a_x = {{(X_W-COORD_BITS){i_rel_x[COORD_BITS-1]}}, i_rel_x}
              + {{(X_W-BASE_W){1'b0}}, i_origin_x};
        n_a_y = {{(X_W-COORD_BITS){i_rel_y[COORD_BITS-1]}}, i_rel_y}
              + {{(X_W-BASE_W){1'b0}}, i_origin_y};
        w_rx  = {{(X_W-BASE_W){1'b0}}, i_base_length} - r_a_x;
        // only the squares matter, so fold the sign away
        w_alx = r_a_x[X_W-1] ? (X_W'(0) - r_a_x) : r_a_x;
        w_arx = w_rx[X_W-1]  ? (X_W'(0) - w_rx)  : w_rx;
        w_ay  = r_a_y[X_W-1] ? (X_W'(0) - r_a_y) : r_a_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d.valid <= r_c_valid;
        end
        if (i_en) begin
            r_a_x       <= n_a_x;
            r_a_y       <= n_a_y;
            r_b_lx      <= w_alx[MAG_W-1:0];
            r_b_rx      <= w_arx[MAG_W-1:0];
            r_b_y       <= w_ay[MAG_W-1:0];
            r_c_lx2     <= SQ_W'(r_b_lx) * SQ_W'(r_b_lx);
            r_c_rx2     <= SQ_W'(r_b_rx) * SQ_W'(r_b_rx);
            r_c_y2      <= SQ_W'(r_b_y) * SQ_W'(r_b_y);
            r_d.left_sum  <= SUM_W'(r_c_lx2) + SUM_W'(r_c_y2);
            r_d.right_sum <= SUM_W'(r_c_rx2) + SUM_W'(r_c_y2);
        end
    end

    assign o_q = r_d;

endmodule

>>> hdl/pcs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pcs_sqrt_cell
// One square-root digit cell: resolves one root bit of both cords per pass
// ----------------------------------------------------------------------------
module pcs_sqrt_cell
    import pcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell r_q;
    t_cell n_q;

    always_comb begin
        n_q.valid = i_d.valid;
        n_q.left  = sqrt_step(i_d.left);
        n_q.right = sqrt_step(i_d.right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q.valid <= n_q.valid;
        end
        if (i_en) begin
            r_q.left  <= n_q.left;
            r_q.right <= n_q.right;
        end
    end

    assign o_q = r_q;

endmodule

>>> hdl/polar_plotter_cord_stepper.sv
// ----------------------------------------------------------------------------
// polar_plotter_cord_stepper
// Cord-length inverse kinematics for a two-cord hanging plotter
// ----------------------------------------------------------------------------
// Each item is a target point relative to the configured origin; the block
// returns the signed step counts that take the left and right motors from
// their kept cord lengths to the new ones (positive lengthens the cord) and
// then keeps the new lengths. The path is a pipeline: four front stages
// (origin add, magnitudes, squares, sums), a chain of 18 square-root cells
// that each settle one root bit of both cords, and the output register. The
// cell chain moves one step per cycle, so a new item is taken every cycle
// while results are being drained; a stalled result freezes the whole chain.
// Start lengths only act through reset, which also restores the reset values
// of those registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polar_plotter_cord_stepper
    import pcs_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_rel_x,
    input  logic signed [COORD_BITS-1:0] i_rel_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DELTA_W-1:0]    o_left_delta,
    output logic signed [DELTA_W-1:0]    o_right_delta,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata
);

    logic [BASE_W-1:0] r_base_length;
    logic [BASE_W-1:0] r_origin_x;
    logic [BASE_W-1:0] r_origin_y;

    logic [LEN_W-1:0]  r_left_len;
    logic [LEN_W-1:0]  r_right_len;

    logic                      r_out_valid;
    logic signed [DELTA_W-1:0] r_left_delta;
    logic signed [DELTA_W-1:0] r_right_delta;

    logic             w_adv;
    t_rad_item        w_front;
    t_cell            w_cell [RW+1];
    t_cell            w_last;
    logic [LEN_W-1:0] w_left_new;
    logic [LEN_W-1:0] w_right_new;

    // the whole chain moves when the output slot is free or being taken
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length <= BASE_LENGTH_RST;
            r_origin_x    <= ORIGIN_X_RST;
            r_origin_y    <= ORIGIN_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE_LENGTH: begin
                    r_base_length <= i_cfg_wdata[BASE_W-1:0];
                end
                REG_ORIGIN_X: begin
                    r_origin_x <= i_cfg_wdata[BASE_W-1:0];
                end
                REG_ORIGIN_Y: begin
                    r_origin_y <= i_cfg_wdata[BASE_W-1:0];
                end
                // start lengths are reloaded by reset together with their defaults
                REG_START_LEFT_LENGTH, REG_START_RIGHT_LENGTH: begin
                end
                default: begin
                end
            endcase
        end
    end

    pcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (i_valid),
        .i_rel_x       (i_rel_x),
        .i_rel_y       (i_rel_y),
        .i_base_length (r_base_length),
        .i_origin_x    (r_origin_x),
        .i_origin_y    (r_origin_y),
        .o_q           (w_front)
    );

    always_comb begin
        w_cell[0].valid      = w_front.valid;
        w_cell[0].left.rad   = RAD_W'(w_front.left_sum);
        w_cell[0].left.rem   = '0;
        w_cell[0].left.root  = '0;
        w_cell[0].right.rad  = RAD_W'(w_front.right_sum);
        w_cell[0].right.rem  = '0;
        w_cell[0].right.root = '0;
    end

    for (genvar g = 0; g < RW; g++) begin : g_cell
        pcs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_d     (w_cell[g]),
            .o_q     (w_cell[g+1])
        );
    end

    assign w_last      = w_cell[RW];
    assign w_left_new  = sat_len(w_last.left.root);
    assign w_right_new = sat_len(w_last.right.root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left_len  <= START_LEFT_RST;
            r_right_len <= START_RIGHT_RST;
        end else if (w_adv) begin
            r_out_valid <= w_last.valid;
            if (w_last.valid) begin
                r_left_len  <= w_left_new;
                r_right_len <= w_right_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last.valid) begin
            r_left_delta  <= $signed({1'b0, w_left_new}) - $signed({1'b0, r_left_len});
            r_right_delta <= $signed({1'b0, w_right_new}) - $signed({1'b0, r_right_len});
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_delta  = r_left_delta;
    assign o_right_delta = r_right_delta;

    `ASSERT_NEXT(a_result_loads, i_clk, i_rst_n, w_adv && w_last.valid, o_valid)
    `ASSERT_NEXT(a_kept_follows, i_clk, i_rst_n, w_adv && w_last.valid, r_left_len == $past(w_left_new) && r_right_len == $past(w_right_new))
    `ASSERT_NEXT(a_delta_match, i_clk, i_rst_n, w_adv && w_last.valid, o_left_delta == ($signed({1'b0, r_left_len}) - $signed({1'b0, $past(r_left_len)})))
    `ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

>>> verif/polar_plotter_cord_stepper_test.sv
// ----------------------------------------------------------------------------
// polar_plotter_cord_stepper_test
// Self-checking bench for the cord stepper: a directed table of target points
// and then random point streams under several anchor and origin settings. A
// local model of the cord math predicts the step deltas of every accepted
// item, and the results are checked in order while both sides idle at random.
// ----------------------------------------------------------------------------
module polar_plotter_cord_stepper_test;
    import pcs_pkg::*;

    localparam int DIRECTED_ROWS  = 17;
    localparam int RANDOM_PER_SET = 320;
    localparam int SETTINGS_COUNT = 6;
    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 4000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(7);

    typedef struct packed {
        logic [DELTA_W-1:0] left;
        logic [DELTA_W-1:0] right;
    } t_cord_move;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  typed;
        logic [DELTA_W-1:0]    left;
        logic [DELTA_W-1:0]    right;
    } t_point_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic signed [COORD_BITS-1:0] i_rel_x;
    logic signed [COORD_BITS-1:0] i_rel_y;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [DELTA_W-1:0]    o_left_delta;
    logic signed [DELTA_W-1:0]    o_right_delta;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_wdata;

    polar_plotter_cord_stepper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rel_x       (i_rel_x),
        .i_rel_y       (i_rel_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_left_delta  (o_left_delta),
        .o_right_delta (o_right_delta),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model copy of the settings and the kept cord lengths
    logic [BASE_W-1:0] anchor_span = BASE_LENGTH_RST;
    logic [BASE_W-1:0] home_x      = ORIGIN_X_RST;
    logic [BASE_W-1:0] home_y      = ORIGIN_Y_RST;
    logic [LEN_W-1:0]  kept_left   = START_LEFT_RST;
    logic [LEN_W-1:0]  kept_right  = START_RIGHT_RST;

    t_cord_move pending_moves[$];
    int         mismatches  = 0;
    int         fault_count = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    logic [9:0] stall_cycle = '0;
    int         stall_pct;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res  = 0;
        rem  = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] cord_len(input longint dx, input longint dy);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned r;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        r  = floor_sqrt(mx * mx + my * my);
        if (r > longint'(LEN_MAX)) begin
            return LEN_MAX;
        end
        return LEN_W'(r);
    endfunction

    function automatic t_cord_move predict_cord_moves(input logic [COORD_BITS-1:0] px,
                                                      input logic [COORD_BITS-1:0] py);
        longint     ax;
        longint     ay;
        logic [LEN_W-1:0] nl;
        logic [LEN_W-1:0] nr;
        t_cord_move mv;
        ax = longint'($signed(px)) + longint'(home_x);
        ay = longint'($signed(py)) + longint'(home_y);
        nl = cord_len(ax, ay);
        nr = cord_len(longint'(anchor_span) - ax, ay);
        mv.left    = DELTA_W'(longint'(nl) - longint'(kept_left));
        mv.right   = DELTA_W'(longint'(nr) - longint'(kept_right));
        kept_left  = nl;
        kept_right = nr;
        return mv;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BASE_LENGTH: anchor_span = data[BASE_W-1:0];
            REG_ORIGIN_X:    home_x      = data[BASE_W-1:0];
            REG_ORIGIN_Y:    home_y      = data[BASE_W-1:0];
            // start lengths only load at reset, which happens once
            REG_START_LEFT_LENGTH, REG_START_RIGHT_LENGTH: ;
            default: ;
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] last);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            return COORD_BITS'($urandom);
        end else if (sel <= 7) begin
            case ($urandom_range(0, 4))
                0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
                1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
                2:       return '0;
                3:       return '1;
                default: return COORD_BITS'(1);
            endcase
        end else if (sel == 8) begin
            // short plotter move from the last point
            return last + COORD_BITS'($urandom_range(0, 64)) - COORD_BITS'(32);
        end
        return last;
    endfunction

    task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                              input logic typed, input t_cord_move typed_move);
        t_cord_move mv;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_rel_x <= px;
        i_rel_y <= py;
        do @(posedge i_clk); while (o_stall);
        mv = predict_cord_moves(px, py);
        pending_moves.push_back(typed ? typed_move : mv);
    endtask

    // let every item drain and the pipeline fall quiet
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_setting(input logic [CFG_DATA_W-1:0] base,
                                   input logic [CFG_DATA_W-1:0] ox,
                                   input logic [CFG_DATA_W-1:0] oy,
                                   input logic [CFG_DATA_W-1:0] sl,
                                   input logic [CFG_DATA_W-1:0] sr);
        logic [CFG_IDX_W-1:0]  idx[6];
        logic [CFG_DATA_W-1:0] val[6];
        idx = '{REG_BASE_LENGTH, REG_ORIGIN_X, REG_ORIGIN_Y, REG_START_LEFT_LENGTH,
                REG_START_RIGHT_LENGTH,
                CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI))};
        val = '{base, ox, oy, sl, sr, CFG_DATA_W'($urandom)};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_wdata <= val[k];
            @(posedge i_clk);
            apply_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // result side: check in order, stall on a pattern that drifts over time
    always @(posedge i_clk) begin
        t_cord_move want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_moves.size() == 0) begin
                fault_count++;
                if (mismatches < 10) begin
                    $display("unexpected item: left %0d right %0d",
                             o_left_delta, o_right_delta);
                end
                mismatches++;
            end else begin
                want = pending_moves.pop_front();
                if (o_left_delta !== want.left || o_right_delta !== want.right) begin
                    fault_count++;
                    if (mismatches < 10) begin
                        $display("delta mismatch: expected left %0d right %0d, got %0d %0d",
                                 $signed(want.left), $signed(want.right),
                                 o_left_delta, o_right_delta);
                    end
                    mismatches++;
                end
            end
        end
        case (stall_cycle[9:8])
            2'd0:    stall_pct = 0;
            2'd1:    stall_pct = 25;
            2'd2:    stall_pct = 70;
            default: stall_pct = 10;
        endcase
        stall_cycle <= stall_cycle + 1'b1;
        i_stall     <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // quiet-cycle watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("polar_plotter_cord_stepper regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_point_row            directed_rows[DIRECTED_ROWS];
        t_cord_move            typed_move;
        logic [COORD_BITS-1:0] rx;
        logic [COORD_BITS-1:0] ry;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rel_x     <= '0;
        i_rel_y     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_BASE_LENGTH;
        i_cfg_wdata <= '0;
        // first rows follow from the reset settings; the rest go to the model
        directed_rows = '{
            '{16'd0, 16'd0, 1'b1, DELTA_W'(-2), DELTA_W'(-1)},
            '{16'd0, 16'd0, 1'b1, DELTA_W'(0), DELTA_W'(0)},
            '{16'(-12639), 16'(-8580), 1'b1, DELTA_W'(-15276), DELTA_W'(10187)},
            '{16'd13780, 16'(-8580), 1'b1, DELTA_W'(26419), DELTA_W'(-26419)},
            '{16'h8000, 16'h8000, 1'b0, '0, '0},
            '{16'h7FFF, 16'h7FFF, 1'b0, '0, '0},
            '{16'h8000, 16'h7FFF, 1'b0, '0, '0},
            '{16'h7FFF, 16'h8000, 1'b0, '0, '0},
            '{16'h0001, 16'h0000, 1'b0, '0, '0},
            '{16'h0000, 16'h0001, 1'b0, '0, '0},
            '{16'hFFFF, 16'hFFFF, 1'b0, '0, '0},
            '{16'h5555, 16'hAAAA, 1'b0, '0, '0},
            '{16'hAAAA, 16'h5555, 1'b0, '0, '0},
            '{16'h7FFF, 16'h0000, 1'b0, '0, '0},
            '{16'h8000, 16'h0000, 1'b0, '0, '0},
            '{16'h0000, 16'h8000, 1'b0, '0, '0},
            '{16'hFFFF, 16'h7FFF, 1'b0, '0, '0}
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            typed_move.left  = directed_rows[r].left;
            typed_move.right = directed_rows[r].right;
            send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].typed,
                       typed_move);
        end
        rx = '0;
        ry = '0;
        for (int s = 0; s < SETTINGS_COUNT; s++) begin
            if (s != 0) begin
                settle();
                case (s)
                    // wide data: bits above the register width must drop
                    1: program_setting('1, '0, '0, '0, '1);
                    2: program_setting('0, 18'h0FFFF, 18'h0FFFF, '1, '0);
                    5: program_setting(18'h0FFFF, '0, 18'h0FFFF,
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                    default: program_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                             CFG_DATA_W'($urandom));
                endcase
            end
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                rx = pick_coord(rx);
                ry = pick_coord(ry);
                send_point(rx, ry, 1'b0, '0);
            end
        end
        settle();

        if (fault_count == 0 && pending_moves.size() == 0) begin
            $display("polar_plotter_cord_stepper regression: pass");
        end else begin
            $display("polar_plotter_cord_stepper regression: fail");
        end
        $finish;
    end

endmodule

>>> polar_plotter_cord_stepper.f
+incdir+hdl
hdl/pcs_pkg.sv
hdl/pcs_front.sv
hdl/pcs_sqrt_cell.sv
hdl/polar_plotter_cord_stepper.sv
verif/polar_plotter_cord_stepper_test.sv
